@@ rtl/core/wtk_pkg.sv @@
// ============================================================================
// wtk_pkg: shared types and constants for the windowed top-K id counter
// Table and list sizes, field widths, stream packing and the FSM encoding.
// ============================================================================
`default_nettype none

package wtk_pkg;

  // Table and list sizes
  localparam int ID_SLOTS = 1024;
  localparam int TOP_K    = 10;
  localparam int ID_AW    = $clog2(ID_SLOTS);

  // Field widths
  localparam int TS_W     = 64;
  localparam int RID_W    = 10;
  localparam int CNT_W    = 32;
  localparam int RANK_W   = 4;

  // Stream packing (payload padded to whole bytes)
  localparam int IN_BITS     = TS_W + RID_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = RANK_W + RID_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] CFG_START_TIME = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_END_TIME   = 1'd1;

  // Request kinds on the input tuser bit
  localparam logic OP_COUNT  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Control FSM
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_EMIT
  } state_e;

  // Count request into the table
  typedef struct packed {
    logic             valid;
    logic [ID_AW-1:0] id;
  } cnt_req_t;

  // Sweep request: scan reads and zeroes, clear only zeroes
  typedef struct packed {
    logic             rd_en;
    logic             clr_en;
    logic [ID_AW-1:0] addr;
  } scan_req_t;

  // Top list control
  typedef struct packed {
    logic ins_valid;
    logic shift;
    logic clear;
  } list_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/windowed_top_k_id_counter_unit.sv @@
// ============================================================================
// windowed_top_k_id_counter_unit: windowed per-id hit counter with top-K report
// Counts in-window log entries per resource id and reports the top ranks.
// ============================================================================
// Usage:
//   Input stream: tuser = 0 is a log entry, tuser = 1 a report request.
//   Log entries are taken one per cycle while idle; an entry whose timestamp lies in
//   [start_time, end_time] bumps its id's saturating 32-bit count through a
//   read-modify-write on the count RAM, with forwarding between
//   back-to-back entries. Log entries give no result.
//   A report request drops input tready while the RAM port sweeps all ids
//   in ascending order, feeding the top list and zeroing each entry, and
//   while it then emits one result per filled rank (at most TOP_K, one per
//   cycle when the receiver is ready), tlast on the final one. With no
//   counts a single result with found (tuser) = 0 is sent. The list then
//   clears.
//   Output goes through a result register; a stall on the receiver holds it
//   and pauses emission, while input of the next batch resumes once the last
//   result is loaded.
//   After reset a clearing pass zeroes the count RAM with input tready low.
//   Config writes (cfg_addr 0 = start_time, 1 = end_time) are taken in any
//   cycle and should be made while the block is idle.
// ============================================================================
`default_nettype none

module windowed_top_k_id_counter_unit
  import wtk_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_AW-1:0]      cfg_addr_i,
  input  logic [TS_W-1:0]        cfg_wdata_i,
  // Input stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // timestamp[63:0], resource_id[73:64]
  input  logic                   s_axis_tuser_i,  // op
  // Result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // rank[3:0], top_id[13:4], hit_count[45:14]
  output logic                   m_axis_tuser_o,  // found
  output logic                   m_axis_tlast_o   // last
);

  state_e state_q, state_d;

  logic [TS_W-1:0]   start_q;
  logic [TS_W-1:0]   end_q;
  logic [ID_AW-1:0]  idx_q, idx_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic              ins_valid_q;
  logic [ID_AW-1:0]  ins_id_q;

  logic              out_valid_q;
  logic [RANK_W-1:0] out_rank_q;
  logic [RID_W-1:0]  out_id_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_found_q;
  logic              out_last_q;

  logic [TS_W-1:0]   ts;
  logic [RID_W-1:0]  rid;
  logic              in_acc;
  logic              in_window;
  logic              idx_end;
  logic              load;
  logic              emit_last;

  cnt_req_t          cnt_req;
  scan_req_t         scan_req;
  list_ctl_t         list_ctl;
  logic [CNT_W-1:0]  rd_data;
  logic [ID_AW-1:0]  head_id;
  logic [CNT_W-1:0]  head_cnt;
  logic [CNT_W-1:0]  next_cnt;

  // Input unpacking and window check
  assign ts        = s_axis_tdata_i[TS_W-1:0];
  assign rid       = s_axis_tdata_i[TS_W +: RID_W];
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_window = ($signed(ts) >= $signed(start_q)) && ($signed(ts) <= $signed(end_q));
  assign idx_end   = (idx_q == ID_AW'(ID_SLOTS - 1));

  // Emission: result register free or draining
  assign load      = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready_i);
  assign emit_last = (head_cnt == '0) || (next_cnt == '0) ||
                     (rank_q == RANK_W'(TOP_K - 1));

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= {1'b0, {(TS_W-1){1'b1}}};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_START_TIME: start_q <= cfg_wdata_i;
        CFG_END_TIME:   end_q   <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (idx_end) state_d = ST_IDLE;
      ST_IDLE:  if (in_acc && (s_axis_tuser_i == OP_REPORT)) state_d = ST_SCAN;
      ST_SCAN:  if (idx_end) state_d = ST_FLUSH;
      ST_FLUSH: state_d = ST_EMIT;
      ST_EMIT:  if (load && emit_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and counters of the FSM
  always_comb begin
    s_axis_tready_o    = 1'b0;
    idx_d              = idx_q;
    rank_d             = rank_q;
    cnt_req.valid      = 1'b0;
    cnt_req.id         = ID_AW'(rid);
    scan_req.rd_en     = 1'b0;
    scan_req.clr_en    = 1'b0;
    scan_req.addr      = idx_q;
    list_ctl.ins_valid = ins_valid_q;
    list_ctl.shift     = 1'b0;
    list_ctl.clear     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        scan_req.clr_en = 1'b1;
        idx_d           = idx_q + ID_AW'(1);
      end
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cnt_req.valid   = in_acc && (s_axis_tuser_i == OP_COUNT) && in_window &&
                          (32'(rid) < ID_SLOTS);
      end
      ST_SCAN: begin
        scan_req.rd_en = 1'b1;
        idx_d          = idx_q + ID_AW'(1);
      end
      ST_FLUSH: ;
      ST_EMIT: begin
        if (load) begin
          list_ctl.shift = 1'b1;
          list_ctl.clear = emit_last;
          rank_d         = emit_last ? '0 : rank_q + RANK_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      rank_q      <= '0;
      ins_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rank_q      <= rank_d;
      ins_valid_q <= scan_req.rd_en;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Scan and result payload
  always_ff @(posedge clk_i) begin
    ins_id_q <= idx_q;
    if (load) begin
      out_rank_q  <= rank_q;
      out_found_q <= (head_cnt != '0);
      out_last_q  <= emit_last;
      out_id_q    <= (head_cnt != '0) ? RID_W'(head_id) : '0;
      out_cnt_q   <= head_cnt;
    end
  end

  wtk_count_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cnt_i     (cnt_req),
    .scan_i    (scan_req),
    .rd_data_o (rd_data)
  );

  wtk_top_list u_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (list_ctl),
    .ins_id_i   (ins_id_q),
    .ins_cnt_i  (rd_data),
    .head_id_o  (head_id),
    .head_cnt_o (head_cnt),
    .next_cnt_o (next_cnt)
  );

  // Result stream packing
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_cnt_q, out_id_q, out_rank_q});
  assign m_axis_tuser_o  = out_found_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  // A not-found result always closes the report
  a_notfound_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("not-found result without last");

  // A found result carries a nonzero count
  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (out_cnt_q != '0))
    else $error("found result with zero count");
`endif

endmodule

`default_nettype wire

@@ rtl/core/wtk_count_store.sv @@
// ============================================================================
// wtk_count_store: per-id hit count table
// Synchronous RAM with read-modify-write increment and one-deep forwarding;
// the sweep port reads an entry and zeroes it in the same cycle.
// ============================================================================
`default_nettype none

module wtk_count_store
  import wtk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cnt_req_t         cnt_i,
  input  scan_req_t        scan_i,
  output logic [CNT_W-1:0] rd_data_o
);

  logic [CNT_W-1:0] mem_q [ID_SLOTS];
  logic [CNT_W-1:0] rd_q;

  logic             s1_valid_q;
  logic [ID_AW-1:0] s1_id_q;
  logic             fwd_valid_q;
  logic [ID_AW-1:0] fwd_id_q;
  logic [CNT_W-1:0] fwd_val_q;

  logic [ID_AW-1:0] raddr;
  logic             we;
  logic [ID_AW-1:0] waddr;
  logic [CNT_W-1:0] wdata;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] upd;

  // Read address: sweep has the port while it runs
  assign raddr = (scan_i.rd_en || scan_i.clr_en) ? scan_i.addr : cnt_i.id;

  // Current count, bypassing the write that landed with our read
  assign cur = (fwd_valid_q && (fwd_id_q == s1_id_q)) ? fwd_val_q : rd_q;
  assign upd = (cur == CNT_MAX) ? cur : cur + CNT_W'(1);

  // Single write port: increment or sweep zeroing
  assign we    = s1_valid_q || scan_i.rd_en || scan_i.clr_en;
  assign waddr = s1_valid_q ? s1_id_q : scan_i.addr;
  assign wdata = s1_valid_q ? upd : '0;

  // RAM, read-first
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[raddr];
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  // Increment pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= cnt_i.valid;
      fwd_valid_q <= s1_valid_q;
    end
  end

  // Increment pipeline payload
  always_ff @(posedge clk_i) begin
    s1_id_q   <= cnt_i.id;
    fwd_id_q  <= s1_id_q;
    fwd_val_q <= upd;
  end

  assign rd_data_o = rd_q;

`ifndef SYNTHESIS
  // A sweep never shares the write port with a pending increment
  a_no_sweep_on_incr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !scan_i.rd_en && !scan_i.clr_en)
    else $error("sweep overlaps pending increment");

  // New counts are not requested while the table is swept
  a_no_count_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_i.valid |-> !scan_i.rd_en && !scan_i.clr_en)
    else $error("count request during sweep");
`endif

endmodule

`default_nettype wire

@@ rtl/core/wtk_top_list.sv @@
// ============================================================================
// wtk_top_list: sorted top-K list of (id, count)
// One insertion per cycle by parallel compare and shift; emission shifts the
// list toward the head so the head always holds the next rank.
// ============================================================================
`default_nettype none

module wtk_top_list
  import wtk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  list_ctl_t        ctl_i,
  input  logic [ID_AW-1:0] ins_id_i,
  input  logic [CNT_W-1:0] ins_cnt_i,
  output logic [ID_AW-1:0] head_id_o,
  output logic [CNT_W-1:0] head_cnt_o,
  output logic [CNT_W-1:0] next_cnt_o
);

  logic [ID_AW-1:0] ids_q  [TOP_K];
  logic [CNT_W-1:0] cnts_q [TOP_K];
  logic [ID_AW-1:0] ids_d  [TOP_K];
  logic [CNT_W-1:0] cnts_d [TOP_K];
  logic [TOP_K-1:0] gt;

  // Strictly greater: ties keep the earlier (lower) id ahead
  always_comb begin
    for (int k = 0; k < TOP_K; k++) begin
      gt[k] = ins_cnt_i > cnts_q[k];
    end
  end

  // Next list contents
  always_comb begin
    for (int k = 0; k < TOP_K; k++) begin
      ids_d[k]  = ids_q[k];
      cnts_d[k] = cnts_q[k];
      if (ctl_i.clear) begin
        ids_d[k]  = '0;
        cnts_d[k] = '0;
      end else if (ctl_i.shift) begin
        if (k == TOP_K - 1) begin
          ids_d[k]  = '0;
          cnts_d[k] = '0;
        end else begin
          ids_d[k]  = ids_q[(k == TOP_K - 1) ? k : k + 1];
          cnts_d[k] = cnts_q[(k == TOP_K - 1) ? k : k + 1];
        end
      end else if (ctl_i.ins_valid && gt[k]) begin
        if (k == 0 || !gt[(k == 0) ? 0 : k - 1]) begin
          ids_d[k]  = ins_id_i;
          cnts_d[k] = ins_cnt_i;
        end else begin
          ids_d[k]  = ids_q[(k == 0) ? 0 : k - 1];
          cnts_d[k] = cnts_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TOP_K; k++) begin
        ids_q[k]  <= '0;
        cnts_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < TOP_K; k++) begin
        ids_q[k]  <= ids_d[k];
        cnts_q[k] <= cnts_d[k];
      end
    end
  end

  // Head and its successor
  always_comb begin
    next_cnt_o = '0;
    for (int k = 0; k < TOP_K; k++) begin
      if (k == 1) begin
        next_cnt_o = cnts_q[k];
      end
    end
  end

  assign head_id_o  = ids_q[0];
  assign head_cnt_o = cnts_q[0];

`ifndef SYNTHESIS
  // List stays sorted at the head
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_cnt_o >= next_cnt_o)
    else $error("top list out of order");

  // Scan insertion and emission never overlap
  a_ins_vs_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.ins_valid |-> !ctl_i.shift)
    else $error("insert during emission");
`endif

endmodule

`default_nettype wire
